@@ design/assert_macros.svh @@
// Assertion helpers shared by the tokenizer RTL.
// Self-contained; no dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, gated off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle implication");

// Next-cycle implication, gated off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle implication");

`endif

@@ design/bst_pkg.sv @@
// Shared types and constants for the byte stream tokenizer.
// No dependencies.
package bst_pkg;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_LBRACE = 3'd1,
      MODE_RBRACE = 3'd2,
      MODE_STRING = 3'd3,
      MODE_IDENT  = 3'd4,
      MODE_NUMBER = 3'd5
   } mode_type;

   typedef enum logic [3:0] {
      KIND_EOF     = 4'd0,
      KIND_DLBRACE = 4'd1,
      KIND_DRBRACE = 4'd2,
      KIND_DOT     = 4'd3,
      KIND_HASH    = 4'd4,
      KIND_LBRACK  = 4'd5,
      KIND_RBRACK  = 4'd6,
      KIND_ASSIGN  = 4'd7,
      KIND_SEMI    = 4'd8,
      KIND_STRING  = 4'd9,
      KIND_IDENT   = 4'd10,
      KIND_NUMBER  = 4'd11,
      KIND_UNKNOWN = 4'd12
   } kind_type;

   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_EQUALS = 8'h3D;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   // Result queue geometry: room for two beats gates the input side.
   localparam int FIFO_DEPTH = 4;
   localparam int FIFO_PTR_W = 2;
   localparam int FIFO_CNT_W = 3;

   typedef struct packed {
      mode_type    mode;
      logic        quote_single;
      logic [7:0]  held_byte;
      logic        held_valid;
      logic        held_first;
   } lex_state_type;

   typedef struct packed {
      kind_type    kind;
      logic [7:0]  lexeme;
      logic        present;
      logic        start;
      logic        last;
   } res_type;

   typedef struct packed {
      logic [1:0]        count;
      res_type [1:0]     res;
   } step_out_type;

   typedef struct packed {
      logic [FIFO_CNT_W-1:0] count;
      logic                  room_for_two;
   } fifo_status_type;

endpackage

@@ design/bst_lexer_step.sv @@
// Next-state and result logic for one source byte of the tokenizer.
// Depends on bst_pkg.
module bst_lexer_step
   import bst_pkg::*;
(
   input  lex_state_type cur,
   input  logic [7:0]    text_byte,
   input  logic          end_of_text,
   output lex_state_type nxt,
   output step_out_type  step
);

   function automatic kind_type single_kind(input logic [7:0] c);
      kind_type k;
      begin
         case (c)
            CH_DOT:    k = KIND_DOT;
            CH_HASH:   k = KIND_HASH;
            CH_LBRACK: k = KIND_LBRACK;
            CH_RBRACK: k = KIND_RBRACK;
            CH_EQUALS: k = KIND_ASSIGN;
            CH_SEMI:   k = KIND_SEMI;
            default:   k = KIND_UNKNOWN;
         endcase
         return k;
      end
   endfunction

   logic          is_ws, is_dig, is_alp, is_word_c, is_quote;
   logic          flush_emit;
   res_type       flush_res;
   lex_state_type flushed;
   logic          use_flushed;
   lex_state_type idle_base, idle_next;
   res_type       idle_res;
   logic          idle_emit;
   res_type       eof_res;
   kind_type      run_kind;
   logic [7:0]    brace;
   logic [7:0]    quote;

   assign is_ws     = (text_byte == 8'd32) || (text_byte >= 8'd9 && text_byte <= 8'd13);
   assign is_dig    = (text_byte >= 8'h30) && (text_byte <= 8'h39);
   assign is_alp    = ((text_byte >= 8'h61) && (text_byte <= 8'h7A)) ||
                      ((text_byte >= 8'h41) && (text_byte <= 8'h5A));
   assign is_word_c = is_alp || is_dig || (text_byte == CH_UNDER);
   assign is_quote  = (text_byte == CH_DQUOTE) || (text_byte == CH_SQUOTE);
   assign brace     = (cur.mode == MODE_LBRACE) ? CH_LBRACE : CH_RBRACE;
   assign quote     = cur.quote_single ? CH_SQUOTE : CH_DQUOTE;

   always_comb begin
      case (cur.mode)
         MODE_STRING: run_kind = KIND_STRING;
         MODE_IDENT:  run_kind = KIND_IDENT;
         default:     run_kind = KIND_NUMBER;
      endcase
   end

   // Closing the open token.
   always_comb begin
      flush_emit = 1'b1;
      flush_res  = '{kind: KIND_UNKNOWN, lexeme: 8'd0, present: 1'b1,
                     start: 1'b1, last: 1'b1};
      case (cur.mode)
         MODE_LBRACE: flush_res.lexeme = CH_LBRACE;
         MODE_RBRACE: flush_res.lexeme = CH_RBRACE;
         MODE_STRING, MODE_IDENT, MODE_NUMBER: begin
            flush_res.kind = run_kind;
            if (cur.held_valid) begin
               flush_res.lexeme = cur.held_byte;
               flush_res.start  = cur.held_first;
            end else begin
               flush_res.present = 1'b0;
            end
         end
         default: flush_emit = 1'b0;
      endcase
      flushed            = cur;
      flushed.mode       = MODE_IDLE;
      flushed.held_valid = 1'b0;
      flushed.held_first = 1'b0;
   end

   // Lexing a byte from idle.
   assign use_flushed = (cur.mode == MODE_LBRACE) || (cur.mode == MODE_RBRACE) ||
                        (cur.mode == MODE_IDENT) || (cur.mode == MODE_NUMBER);
   assign idle_base   = use_flushed ? flushed : cur;

   always_comb begin
      idle_next            = idle_base;
      idle_next.mode       = MODE_IDLE;
      idle_next.held_valid = 1'b0;
      idle_emit            = 1'b0;
      idle_res = '{kind: single_kind(text_byte), lexeme: text_byte, present: 1'b1,
                   start: 1'b1, last: 1'b1};
      if (is_ws) begin
         idle_emit = 1'b0;
      end else if (text_byte == CH_LBRACE) begin
         idle_next.mode = MODE_LBRACE;
      end else if (text_byte == CH_RBRACE) begin
         idle_next.mode = MODE_RBRACE;
      end else if (is_quote) begin
         idle_next.mode         = MODE_STRING;
         idle_next.quote_single = (text_byte == CH_SQUOTE);
      end else if (is_alp || text_byte == CH_UNDER || is_dig) begin
         idle_next.mode       = is_dig ? MODE_NUMBER : MODE_IDENT;
         idle_next.held_byte  = text_byte;
         idle_next.held_valid = 1'b1;
         idle_next.held_first = 1'b1;
      end else begin
         idle_emit = 1'b1;
      end
   end

   assign eof_res = '{kind: KIND_EOF, lexeme: 8'd0, present: 1'b0,
                      start: 1'b1, last: 1'b1};

   always_comb begin
      nxt        = cur;
      step.count = 2'd0;
      step.res   = '0;
      if (end_of_text) begin
         nxt = flushed;
         if (flush_emit) begin
            step.res[0] = flush_res;
            step.res[1] = eof_res;
            step.count  = 2'd2;
         end else begin
            step.res[0] = eof_res;
            step.count  = 2'd1;
         end
      end else begin
         case (cur.mode)
            MODE_LBRACE, MODE_RBRACE: begin
               if (text_byte == brace) begin
                  step.res[0] = '{kind: (cur.mode == MODE_LBRACE) ? KIND_DLBRACE
                                                                  : KIND_DRBRACE,
                                  lexeme: brace, present: 1'b1,
                                  start: 1'b1, last: 1'b0};
                  step.res[1]       = step.res[0];
                  step.res[1].start = 1'b0;
                  step.res[1].last  = 1'b1;
                  step.count        = 2'd2;
                  nxt.mode          = MODE_IDLE;
               end else begin
                  step.res[0] = flush_res;
                  step.res[1] = idle_res;
                  step.count  = {1'b0, idle_emit} + 2'd1;
                  nxt         = idle_next;
               end
            end
            MODE_STRING, MODE_IDENT, MODE_NUMBER: begin
               if (cur.mode == MODE_STRING && text_byte == quote) begin
                  step.res[0] = flush_res;
                  step.count  = 2'd1;
                  nxt         = flushed;
               end else if (cur.mode == MODE_STRING ||
                            (cur.mode == MODE_IDENT && is_word_c) ||
                            (cur.mode == MODE_NUMBER && is_dig)) begin
                  // Token continues: release the held byte, hold this one.
                  step.res[0] = '{kind: run_kind, lexeme: cur.held_byte, present: 1'b1,
                                  start: cur.held_first, last: 1'b0};
                  step.count     = {1'b0, cur.held_valid};
                  nxt.held_byte  = text_byte;
                  nxt.held_valid = 1'b1;
                  nxt.held_first = !cur.held_valid;
               end else begin
                  step.res[0] = flush_res;
                  step.res[1] = idle_res;
                  step.count  = {1'b0, idle_emit} + 2'd1;
                  nxt         = idle_next;
               end
            end
            default: begin
               step.res[0] = idle_res;
               step.count  = {1'b0, idle_emit};
               nxt         = idle_next;
            end
         endcase
      end
   end

endmodule

@@ design/bst_res_fifo.sv @@
// Four-entry result queue: takes up to two beats a cycle, gives one.
// Depends on bst_pkg.
module bst_res_fifo
   import bst_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic [1:0]      push_count,
   input  res_type [1:0]   push_data,
   input  logic            pop,
   output logic            out_valid,
   output res_type         out_data,
   output fifo_status_type status
);

   res_type                entry_ff [FIFO_DEPTH];
   logic [FIFO_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [FIFO_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [FIFO_CNT_W-1:0]  count_ff, count_in;
   logic [FIFO_PTR_W-1:0]  wr_ptr_next;
   logic                   do_pop;

   assign do_pop      = pop && out_valid;
   assign wr_ptr_next = wr_ptr_ff + 1'b1;
   assign wr_ptr_in   = wr_ptr_ff + push_count[FIFO_PTR_W-1:0];
   assign rd_ptr_in   = rd_ptr_ff + {{(FIFO_PTR_W-1){1'b0}}, do_pop};
   assign count_in    = count_ff + {{(FIFO_CNT_W-2){1'b0}}, push_count}
                                 - {{(FIFO_CNT_W-1){1'b0}}, do_pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_data[0];
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_data[1];
      end
   end

   assign out_valid           = (count_ff != '0);
   assign out_data            = entry_ff[rd_ptr_ff];
   assign status.count        = count_ff;
   assign status.room_for_two = (count_ff <= FIFO_CNT_W'(FIFO_DEPTH - 2));

endmodule

@@ design/byte_stream_tokenizer.sv @@
// Byte stream tokenizer: source bytes in, token lexeme beats out.
// Channels req_ (source bytes) and rsp_ (result beats), valid/ready handshake.
// Input beat: req_text_byte, req_end_of_text. A beat with end-of-text set
// closes any open token (an unterminated string included) and yields EOF.
// Output beat: token kind, one lexeme byte (or none), start and end marks.
// Identifier, number and string bytes are held back one beat so that the
// last byte of a token can carry its end mark; quotes are dropped.
// Each accepted byte yields zero, one or two result beats.
// Results are offered from the cycle after acceptance, behind older beats.
// Throughput: one source byte per cycle while the result queue has room for
// two beats; the output side drains one beat per cycle while rsp_ready is
// high, so a run of bytes each yielding two beats is paced by the output port.
// A receiver stall holds off req_ready once more than two beats wait in the
// four-entry result queue; no beat is dropped or repeated.
// Reset (synchronous, active high) empties the queue and returns the lexer to
// idle with nothing held.
`include "assert_macros.svh"

module byte_stream_tokenizer
   import bst_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_text_byte,
   input  logic       req_end_of_text,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [3:0] rsp_token_kind,
   output logic [7:0] rsp_lexeme_byte,
   output logic       rsp_byte_present,
   output logic       rsp_token_start,
   output logic       rsp_token_end
);

   // Lexer state: mode, quote style and the held-back byte.
   lex_state_type   lex_state_ff, lex_state_in;
   lex_state_type   step_next;
   step_out_type    step;
   fifo_status_type fifo_status;
   res_type         head;
   logic            accept;

   assign accept = req_valid && req_ready;

   bst_lexer_step u_step (
      .cur         (lex_state_ff),
      .text_byte   (req_text_byte),
      .end_of_text (req_end_of_text),
      .nxt         (step_next),
      .step        (step)
   );

   // State only moves on an accepted beat.
   assign lex_state_in = accept ? step_next : lex_state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_state_ff <= '{mode: MODE_IDLE, quote_single: 1'b0, held_byte: 8'd0,
                           held_valid: 1'b0, held_first: 1'b0};
      end else begin
         lex_state_ff <= lex_state_in;
      end
   end

   // Results queue up behind the output port; the queue head is the
   // registered result seen on rsp_.
   bst_res_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_count (accept ? step.count : 2'd0),
      .push_data  (step.res),
      .pop        (rsp_ready),
      .out_valid  (rsp_valid),
      .out_data   (head),
      .status     (fifo_status)
   );

   // Ready depends on registered occupancy only.
   assign req_ready = fifo_status.room_for_two;

   assign rsp_token_kind   = head.kind;
   assign rsp_lexeme_byte  = head.lexeme;
   assign rsp_byte_present = head.present;
   assign rsp_token_start  = head.start;
   assign rsp_token_end    = head.last;

   // Queue never overfills.
   `ASSERT_IMPLIES(a_fifo_bound, clock, reset, 1'b1,
                   fifo_status.count <= FIFO_CNT_W'(FIFO_DEPTH))
   // After an accepted end of text, a beat is offered on the following cycle.
   `ASSERT_NEXT(a_eof_beat, clock, reset, accept && req_end_of_text, rsp_valid)
   // End of text leaves the lexer idle with nothing held.
   `ASSERT_NEXT(a_eof_idle, clock, reset, accept && req_end_of_text,
                lex_state_ff.mode == MODE_IDLE && !lex_state_ff.held_valid)

endmodule
